@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ design/mstc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstc_pkg
// Types, codes and the microcode program of the modal step counter.
// ----------------------------------------------------------------------------
package mstc_pkg;

    localparam int DataW = 32;
    localparam int AccW  = 48;
    localparam int FracW = 16;
    localparam int BndW  = 31;
    localparam int UpcW  = 4;
    localparam int CntW  = 5;
    localparam int ProgLen = 13;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_MODULUS       = 2'd0,
        CFG_STEP_SIZE     = 2'd1,
        CFG_REFLECT_BOUND = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_FETCH,
        UOP_CLEAR,
        UOP_LOAD,
        UOP_MOD_INIT,
        UOP_DIV_STEP,
        UOP_MOD_FIX,
        UOP_STEP_ADD,
        UOP_REF_INIT,
        UOP_REF_FIX,
        UOP_PLAIN,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_NO_ACCEPT,
        JMP_DISPATCH,
        JMP_DIV_MORE,
        JMP_OUT_BUSY
    } jmp_t;

    typedef logic [UpcW-1:0] upc_t;

    localparam upc_t A_FETCH    = 4'd0;
    localparam upc_t A_DECODE   = 4'd1;
    localparam upc_t A_CLEAR    = 4'd2;
    localparam upc_t A_LOAD     = 4'd3;
    localparam upc_t A_MOD_INIT = 4'd4;
    localparam upc_t A_MOD_DIV  = 4'd5;
    localparam upc_t A_MOD_FIX  = 4'd6;
    localparam upc_t A_STEP     = 4'd7;
    localparam upc_t A_REF_INIT = 4'd8;
    localparam upc_t A_REF_DIV  = 4'd9;
    localparam upc_t A_REF_FIX  = 4'd10;
    localparam upc_t A_PLAIN    = 4'd11;
    localparam upc_t A_EMIT     = 4'd12;

    typedef struct packed {
        uop_t uop;
        jmp_t jmp;
        upc_t target;
    } ctrl_word_t;

    typedef struct packed {
        uop_t uop;
        logic in_accept;
    } dp_ctrl_t;

    typedef struct packed {
        op_t  op;
        logic div_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [DataW-1:0] modulus;
        logic [DataW-1:0] step_size;
        logic [BndW-1:0]  reflect_bound;
    } cfg_t;

    function automatic ctrl_word_t ucode_rom(upc_t addr);
        ctrl_word_t cw;
        unique case (addr)
            A_FETCH:    cw = '{uop: UOP_FETCH,    jmp: JMP_NO_ACCEPT, target: A_FETCH};
            A_DECODE:   cw = '{uop: UOP_NOP,      jmp: JMP_DISPATCH,  target: A_FETCH};
            A_CLEAR:    cw = '{uop: UOP_CLEAR,    jmp: JMP_ALWAYS,    target: A_FETCH};
            A_LOAD:     cw = '{uop: UOP_LOAD,     jmp: JMP_ALWAYS,    target: A_FETCH};
            A_MOD_INIT: cw = '{uop: UOP_MOD_INIT, jmp: JMP_NEXT,      target: A_FETCH};
            A_MOD_DIV:  cw = '{uop: UOP_DIV_STEP, jmp: JMP_DIV_MORE,  target: A_MOD_DIV};
            A_MOD_FIX:  cw = '{uop: UOP_MOD_FIX,  jmp: JMP_ALWAYS,    target: A_EMIT};
            A_STEP:     cw = '{uop: UOP_STEP_ADD, jmp: JMP_ALWAYS,    target: A_EMIT};
            A_REF_INIT: cw = '{uop: UOP_REF_INIT, jmp: JMP_NEXT,      target: A_FETCH};
            A_REF_DIV:  cw = '{uop: UOP_DIV_STEP, jmp: JMP_DIV_MORE,  target: A_REF_DIV};
            A_REF_FIX:  cw = '{uop: UOP_REF_FIX,  jmp: JMP_ALWAYS,    target: A_EMIT};
            A_PLAIN:    cw = '{uop: UOP_PLAIN,    jmp: JMP_NEXT,      target: A_FETCH};
            A_EMIT:     cw = '{uop: UOP_EMIT,     jmp: JMP_OUT_BUSY,  target: A_FETCH};
            default:    cw = '{uop: UOP_NOP,      jmp: JMP_ALWAYS,    target: A_FETCH};
        endcase
        return cw;
    endfunction

    function automatic upc_t dispatch(op_t op, cfg_t cfg);
        upc_t dest;
        unique case (op)
            OP_TICK: begin
                if (cfg.modulus != '0) begin
                    dest = A_MOD_INIT;
                end else if (cfg.step_size != '0) begin
                    dest = A_STEP;
                end else if (cfg.reflect_bound != '0) begin
                    dest = A_REF_INIT;
                end else begin
                    dest = A_PLAIN;
                end
            end
            OP_RESET: dest = A_CLEAR;
            OP_LOAD:  dest = A_LOAD;
            default:  dest = A_FETCH;
        endcase
        return dest;
    endfunction

endpackage

@@ design/mstc_useq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstc_useq
// Microsequencer: step counter, program table and jump logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mstc_useq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mstc_pkg::cfg_t       cfg,
    input  mstc_pkg::dp_status_t status,
    output mstc_pkg::dp_ctrl_t   ctrl
);
    import mstc_pkg::*;

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t cw;
    logic       accept;

    assign cw      = ucode_rom(upc_reg);
    assign s_ready = (cw.uop == UOP_FETCH);
    assign accept  = s_valid && s_ready;

    assign ctrl.uop       = cw.uop;
    assign ctrl.in_accept = accept;

    always_comb begin
        unique case (cw.jmp)
            JMP_NEXT:      upc_next = upc_reg + upc_t'(1);
            JMP_ALWAYS:    upc_next = cw.target;
            JMP_NO_ACCEPT: upc_next = accept ? upc_reg + upc_t'(1) : cw.target;
            JMP_DISPATCH:  upc_next = dispatch(status.op, cfg);
            JMP_DIV_MORE:  upc_next = status.div_last ? upc_reg + upc_t'(1) : cw.target;
            JMP_OUT_BUSY:  upc_next = status.out_busy ? upc_reg : cw.target;
            default:       upc_next = A_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    `ASSERT_AT(a_upc_in_program, upc_reg < upc_t'(ProgLen), "step counter left the program")
    `ASSERT_AT(a_accept_to_decode, accept |=> upc_reg == A_DECODE, "accepted beat not decoded")

endmodule

@@ design/mstc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstc_datapath
// Count and accumulator state, shared bit-serial remainder unit, result
// shaping and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mstc_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mstc_pkg::dp_ctrl_t                    ctrl,
    input  mstc_pkg::cfg_t                        cfg,
    input  logic [1:0]                            s_op,
    input  logic signed [mstc_pkg::DataW-1:0]     s_load_value,
    output mstc_pkg::dp_status_t                  status,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mstc_pkg::AccW-1:0]      m_value
);
    import mstc_pkg::*;

    localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
    localparam logic signed [AccW:0] AccMin = {2'b11, {(AccW-1){1'b0}}};

    op_t               op_reg;
    logic [DataW-1:0]  lv_reg;
    logic [DataW-1:0]  count_reg,  count_next;
    logic [AccW-1:0]   acc_reg,    acc_next;
    logic [DataW-1:0]  dvd_reg,    dvd_next;
    logic [DataW:0]    dsr_reg,    dsr_next;
    logic [DataW:0]    rem_reg,    rem_next;
    logic [CntW-1:0]   cnt_reg,    cnt_next;
    logic              neg_reg,    neg_next;
    logic [AccW-1:0]   res_reg,    res_next;
    logic              out_valid_reg, out_valid_next;
    logic [AccW-1:0]   out_value_reg;
    logic              out_busy;

    logic [DataW-1:0]  count_inc;
    logic [DataW-1:0]  count_abs;
    logic [DataW-1:0]  mod_abs;
    logic [DataW+1:0]  ref_sum;
    logic [DataW+1:0]  ref_abs;
    logic [DataW+1:0]  trial;
    logic [DataW+2:0]  diff;
    logic [DataW-1:0]  rt;
    logic [DataW-1:0]  mod_res;
    logic              v_low;
    logic [DataW+1:0]  ref_a;
    logic [DataW+1:0]  ref_b;
    logic [DataW-1:0]  ref_res;
    logic [AccW:0]     acc_sum;
    logic [AccW-1:0]   acc_sat;
    logic [FracW-1:0]  load_int;

    assign out_busy = out_valid_reg && !m_ready;

    assign status.op       = op_reg;
    assign status.div_last = &cnt_reg;
    assign status.out_busy = out_busy;

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;

    always_comb begin
        count_inc = count_reg + DataW'(1);
        count_abs = count_reg[DataW-1] ? -count_reg : count_reg;
        mod_abs   = cfg.modulus[DataW-1] ? -cfg.modulus : cfg.modulus;

        ref_sum = {{2{count_inc[DataW-1]}}, count_inc} + {3'b000, cfg.reflect_bound};
        ref_abs = ref_sum[DataW+1] ? -ref_sum : ref_sum;

        trial = {rem_reg, dvd_reg[DataW-1]};
        diff  = {1'b0, trial} - {2'b00, dsr_reg};

        rt = neg_reg ? -rem_reg[DataW-1:0] : rem_reg[DataW-1:0];
        if (rt != '0 && rt[DataW-1] != cfg.modulus[DataW-1]) begin
            mod_res = rt + cfg.modulus;
        end else begin
            mod_res = rt;
        end

        v_low   = rem_reg <= {1'b0, cfg.reflect_bound, 1'b0};
        ref_a   = {1'b0, rem_reg} - {3'b000, cfg.reflect_bound};
        ref_b   = {2'b00, cfg.reflect_bound, 1'b0} + {3'b000, cfg.reflect_bound}
                  - {1'b0, rem_reg};
        ref_res = v_low ? ref_a[DataW-1:0] : ref_b[DataW-1:0];

        acc_sum = {acc_reg[AccW-1], acc_reg}
                  + {{(AccW-DataW+1){cfg.step_size[DataW-1]}}, cfg.step_size};
        if (acc_sum[AccW] != acc_sum[AccW-1]) begin
            acc_sat = acc_sum[AccW] ? AccMin[AccW-1:0] : AccMax[AccW-1:0];
        end else begin
            acc_sat = acc_sum[AccW-1:0];
        end

        load_int = lv_reg[DataW-1:FracW]
                   + FracW'(lv_reg[DataW-1] && lv_reg[FracW-1:0] != '0);
    end

    always_comb begin
        count_next = count_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        unique case (ctrl.uop)
            UOP_CLEAR: begin
                count_next = '0;
                acc_next   = '0;
            end
            UOP_LOAD: begin
                count_next = {{(DataW-FracW){load_int[FracW-1]}}, load_int};
                acc_next   = {{(AccW-DataW){lv_reg[DataW-1]}}, lv_reg};
            end
            UOP_MOD_INIT: begin
                count_next = count_inc;
                dvd_next   = count_abs;
                dsr_next   = {1'b0, mod_abs};
                rem_next   = '0;
                cnt_next   = '0;
                neg_next   = count_reg[DataW-1];
            end
            UOP_REF_INIT: begin
                count_next = count_inc;
                dvd_next   = ref_abs[DataW-1:0];
                dsr_next   = {cfg.reflect_bound, 2'b00};
                rem_next   = '0;
                cnt_next   = '0;
                neg_next   = 1'b0;
            end
            UOP_DIV_STEP: begin
                rem_next = diff[DataW+2] ? trial[DataW:0] : diff[DataW:0];
                dvd_next = {dvd_reg[DataW-2:0], 1'b0};
                cnt_next = cnt_reg + CntW'(1);
            end
            UOP_MOD_FIX: begin
                res_next = {mod_res, {FracW{1'b0}}};
            end
            UOP_REF_FIX: begin
                res_next = {ref_res, {FracW{1'b0}}};
            end
            UOP_STEP_ADD: begin
                count_next = count_inc;
                acc_next   = acc_sat;
                res_next   = acc_sat;
            end
            UOP_PLAIN: begin
                count_next = count_inc;
                res_next   = {count_reg, {FracW{1'b0}}};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (ctrl.uop == UOP_EMIT && !out_busy) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.in_accept) begin
            op_reg <= op_t'(s_op);
            lv_reg <= s_load_value;
        end
        if (ctrl.uop == UOP_EMIT && !out_busy) begin
            out_value_reg <= res_reg;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    `ASSERT_AT(a_rem_below_divisor,
        (ctrl.uop == UOP_MOD_FIX || ctrl.uop == UOP_REF_FIX) |-> rem_reg < dsr_reg,
        "remainder not below divisor after division")
    `ASSERT_AT(a_pending_result_kept,
        (ctrl.uop == UOP_EMIT && out_busy) |=> $stable(out_value_reg),
        "pending result overwritten")

endmodule

@@ design/modal_step_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modal_step_counter
// Tick counter with modulus, step-accumulator, reflect and plain output modes,
// run by a microcoded sequencer over a shared bit-serial remainder unit.
//
//   Channel  Dir  Ports                                  Beat
//   s_       in   s_valid s_ready s_op s_load_value       one command
//   m_       out  m_valid m_ready m_value                 one tick result
//   cfg_     in   cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// Every command is fetched and decoded; a tick ends with an emit step, and in
// modulus or reflect mode it runs 32 remainder steps of the shared unit before it.
// A result waits in the output register; the next command is taken meanwhile,
// and a following tick stalls in its emit step until the result is taken.
// Reset is synchronous, active low, and clears count, accumulator and registers.
// Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module modal_step_counter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_op,
    input  logic signed [mstc_pkg::DataW-1:0]     s_load_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mstc_pkg::AccW-1:0]      m_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [mstc_pkg::DataW-1:0]            cfg_data
);
    import mstc_pkg::*;

    logic [DataW-1:0] modulus_reg;
    logic [DataW-1:0] step_size_reg;
    logic [BndW-1:0]  reflect_bound_reg;
    cfg_t             cfg;
    dp_ctrl_t         ctrl;
    dp_status_t       status;

    assign cfg_ready = 1'b1;

    assign cfg.modulus       = modulus_reg;
    assign cfg.step_size     = step_size_reg;
    assign cfg.reflect_bound = reflect_bound_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg       <= '0;
            step_size_reg     <= '0;
            reflect_bound_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODULUS:       modulus_reg       <= cfg_data;
                CFG_STEP_SIZE:     step_size_reg     <= cfg_data;
                CFG_REFLECT_BOUND: reflect_bound_reg <= cfg_data[BndW-1:0];
                default: begin
                end
            endcase
        end
    end

    mstc_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cfg     (cfg),
        .status  (status),
        .ctrl    (ctrl)
    );

    mstc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .s_op         (s_op),
        .s_load_value (s_load_value),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

endmodule

@@ bench/modal_step_counter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modal_step_counter_test
// Self-checking bench for the modal step counter. A short table of commands
// walks the four output modes, load truncation, the ignored op and register
// codes and the register extremes. Random phases follow, each with fresh
// register settings and a sender and receiver idling mix. Every tick
// result is compared with its table value or a cycle-free model of the counter state.
// ----------------------------------------------------------------------------
module modal_step_counter_test;
    import mstc_pkg::*;

    localparam logic [1:0] OpSpare  = 2'd3;
    localparam logic [1:0] CfgSpare = 2'd3;
    localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint AccMin = -AccMax - 1;
    localparam int SettleCycles = 48;
    localparam int ItemsPerPhase = 50;

    typedef enum int {MODE_MODULUS, MODE_STEP, MODE_REFLECT, MODE_PLAIN} mode_t;

    typedef struct packed {
        logic        is_reg;
        logic [1:0]  code;
        logic [31:0] data;
        logic        typed;
        logic [47:0] want;
    } vector_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_op = OP_TICK;
    logic signed [DataW-1:0]  s_load_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [AccW-1:0]   m_value;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = CFG_MODULUS;
    logic [DataW-1:0]         cfg_data = '0;

    // counter model state and registers
    logic [31:0]        count_q = '0;
    logic signed [47:0] acc_q = '0;
    logic signed [31:0] modulus_q = '0;
    logic signed [31:0] step_q = '0;
    logic [30:0]        bound_q = '0;

    logic [47:0] owed_values[$];
    vector_t     directed_rows[$];

    int n_bad = 0;
    int n_results = 0;
    int n_cmds = 0;
    int n_writes = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;

    modal_step_counter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_load_value (s_load_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [47:0] to_q16(input longint whole);
        longint scaled;
        scaled = whole * 65536;
        return scaled[47:0];
    endfunction

    function automatic logic advance_counter(input logic [1:0] op, input logic [31:0] lv,
                                             output logic [47:0] res);
        longint prev, m, r, s, t, u, v;
        prev = $signed(count_q);
        res = '0;
        case (op)
            OP_TICK: begin
                count_q = count_q + 32'd1;
                if (modulus_q != '0) begin
                    m = modulus_q;
                    r = prev % m;
                    if (r != 0 && ((r < 0) != (m < 0))) begin
                        r = r + m;
                    end
                    res = to_q16(r);
                end else if (step_q != '0) begin
                    s = acc_q + step_q;
                    if (s > AccMax) begin
                        s = AccMax;
                    end
                    if (s < AccMin) begin
                        s = AccMin;
                    end
                    acc_q = s[47:0];
                    res = s[47:0];
                end else if (bound_q != '0) begin
                    r = bound_q;
                    t = $signed(count_q);
                    u = t + r;
                    if (u < 0) begin
                        u = -u;
                    end
                    v = u % (4 * r);
                    res = to_q16((v <= 2 * r) ? v - r : 3 * r - v);
                end else begin
                    res = to_q16(prev);
                end
                return 1'b1;
            end
            OP_RESET: begin
                count_q = '0;
                acc_q = '0;
            end
            OP_LOAD: begin
                s = $signed(lv);
                t = s / 65536;
                count_q = t[31:0];
                acc_q = s[47:0];
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_MODULUS:       modulus_q = data;
            CFG_STEP_SIZE:     step_q = data;
            CFG_REFLECT_BOUND: bound_q = data[30:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_setting();
        logic [31:0] val;
        val = $urandom_range(1, 9);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: val = '0;
            4: val = $urandom_range(0, 1) ? -val : val;
            5: val = $urandom();
            6: begin
                case ($urandom_range(0, 2))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    default: val = 32'hFFFF_FFFF;
                endcase
            end
            default: val = $urandom_range(1, 255) << 16;
        endcase
        return val;
    endfunction

    // entered and left at a falling edge; valid stays high on return
    task automatic push_command(input logic [1:0] op, input logic [31:0] lv,
                                input logic typed, input logic [47:0] want);
        logic [47:0] v;
        s_valid <= 1'b1;
        s_op <= op;
        s_load_value <= lv;
        do @(posedge aclk); while (!s_ready);
        n_cmds++;
        if (advance_counter(op, lv, v)) begin
            owed_values.push_back(typed ? want : v);
        end
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        n_writes++;
        apply_register(idx, data);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (owed_values.size() != 0);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic program_registers(input logic [31:0] mod_v, input logic [31:0] step_v,
                                     input logic [31:0] bound_v);
        settle();
        write_register(CFG_MODULUS, mod_v);
        write_register(CFG_STEP_SIZE, step_v);
        write_register(CFG_REFLECT_BOUND, bound_v);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic is_reg, input logic [1:0] code, input logic [31:0] data,
                           input logic typed, input logic [47:0] want);
        vector_t row;
        row.is_reg = is_reg;
        row.code = code;
        row.data = data;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        logic [47:0] want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (owed_values.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("unexpected result %h with nothing pending", m_value);
                end
            end else begin
                want = owed_values.pop_front();
                if (m_value !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("value mismatch: expected %h, got %h", want, m_value);
                    end
                end
            end
        end
    end

    initial begin
        logic [1:0]  op;
        logic [31:0] lv, mod_v, step_v, bound_v;
        mode_t       mode;
        int          sent, pick;

        // plain mode, load truncation and the spare op code
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_0000_0000);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_0001_0000);
        add_row(1'b0, OP_LOAD, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_7FFF_0000);
        add_row(1'b0, OP_LOAD, 32'h8000_0000, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'hFFFF_8000_0000);
        add_row(1'b0, OpSpare, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'hFFFF_8001_0000);
        add_row(1'b0, OP_LOAD, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_0000_0000);
        add_row(1'b0, OP_RESET, '0, 1'b0, '0);
        // modulus signs and extremes
        add_row(1'b1, CFG_MODULUS, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_0000_0000);
        add_row(1'b1, CFG_MODULUS, 32'd7, 1'b0, '0);
        add_row(1'b0, OP_LOAD, 32'hFFFB_0000, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'h0000_0002_0000);
        add_row(1'b1, CFG_MODULUS, 32'hFFFF_FFF9, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b1, 48'hFFFF_FFFC_0000);
        add_row(1'b1, CFG_MODULUS, 32'h8000_0000, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        add_row(1'b1, CFG_MODULUS, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        // step mode with the most negative step
        add_row(1'b1, CFG_MODULUS, '0, 1'b0, '0);
        add_row(1'b1, CFG_STEP_SIZE, 32'h8000_0000, 1'b0, '0);
        add_row(1'b0, OP_LOAD, 32'h0001_8000, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        // reflect mode, spare register index, widest bound
        add_row(1'b1, CFG_STEP_SIZE, '0, 1'b0, '0);
        add_row(1'b1, CFG_REFLECT_BOUND, 32'd3, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        add_row(1'b0, OP_LOAD, 32'hFFFC_0000, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        add_row(1'b1, CfgSpare, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);
        add_row(1'b1, CFG_REFLECT_BOUND, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, OP_TICK, '0, 1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg) begin
                settle();
                write_register(directed_rows[i].code, directed_rows[i].data);
                cfg_valid <= 1'b0;
            end else begin
                push_command(directed_rows[i].code, directed_rows[i].data,
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int phase = 0; phase < 8; phase++) begin
            mode = mode_t'(phase % 4);
            mod_v = pick_setting();
            step_v = pick_setting();
            bound_v = pick_setting();
            if (mode == MODE_MODULUS) begin
                while (mod_v == '0) mod_v = pick_setting();
            end else begin
                mod_v = '0;
            end
            if (mode == MODE_STEP) begin
                while (step_v == '0) step_v = pick_setting();
            end else if (mode != MODE_MODULUS) begin
                step_v = '0;
            end
            if (mode == MODE_REFLECT) begin
                while (bound_v[30:0] == '0) bound_v = pick_setting();
            end else if (mode == MODE_PLAIN) begin
                bound_v = '0;
            end
            program_registers(mod_v, step_v, bound_v);

            case (phase / 2)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 45; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 45; end
                default: begin tx_gap_pct = 25; rx_stall_pct = 25; end
            endcase

            sent = 0;
            while (sent < ItemsPerPhase) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    op = OP_TICK;
                end else if (pick < 88) begin
                    op = OP_LOAD;
                end else if (pick < 95) begin
                    op = OP_RESET;
                end else begin
                    op = OpSpare;
                end
                lv = $urandom();
                if ($urandom_range(0, 1) != 0) begin
                    lv = $signed(lv) >>> 10;
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_for_results();
                end else if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
                    s_valid <= 1'b0;
                    do @(negedge aclk); while ($urandom_range(0, 99) < tx_gap_pct);
                end
                push_command(op, lv, 1'b0, '0);
                if (op != OpSpare) begin
                    sent++;
                end
            end
        end

        settle();
        if (owed_values.size() != 0) begin
            n_bad += owed_values.size();
        end
        $display("ran %0d commands and %0d register writes, %0d tick results checked",
                 n_cmds, n_writes, n_results);
        $display("covered all four output modes, the register extremes and four idle mixes");
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ modal_step_counter.f @@
+incdir+design
design/mstc_pkg.sv
design/mstc_useq.sv
design/mstc_datapath.sv
design/modal_step_counter.sv
bench/modal_step_counter_test.sv
